// ----- src/cvxq_pkg.sv -----
// Package for the convex polygon query block: sizes, codes, shared types.
// Used by cvxq_vstore, cvxq_dot_unit and convex_polygon_query.
package cvxq_pkg;

  localparam int MAX_VERTICES = 16;
  localparam int COORD_WIDTH  = 16;
  localparam int IDX_W        = $clog2(MAX_VERTICES);
  localparam int NCNT_W       = IDX_W + 1;
  localparam int CNT_W        = 5;
  localparam int SLOT_W       = 4;
  localparam int FUNC_W       = 2;
  // operand width covers 2*q - 2*v - e
  localparam int OPW          = COORD_WIDTH + 3;
  localparam int PROD_W       = 2 * OPW;
  localparam int DOT_W        = PROD_W + 1;

  typedef logic signed [COORD_WIDTH-1:0] cvxq_coord_t;
  typedef logic signed [OPW-1:0]         cvxq_op_t;
  typedef logic signed [PROD_W-1:0]      cvxq_prod_t;
  typedef logic signed [DOT_W-1:0]       cvxq_dotv_t;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD    = 2'd0,
    FUNC_SUPPORT = 2'd1,
    FUNC_CONTAIN = 2'd2
  } cvxq_func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_FINISH
  } cvxq_state_t;

  // vertex data that rides along with a dot product
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    cvxq_coord_t      x;
    cvxq_coord_t      y;
  } cvxq_tag_t;

  // request into the shared dot unit: sub selects a0*b0 - a1*b1
  typedef struct packed {
    logic      valid;
    logic      sub;
    cvxq_op_t  a0;
    cvxq_op_t  b0;
    cvxq_op_t  a1;
    cvxq_op_t  b1;
    cvxq_tag_t tag;
  } cvxq_req_t;

  // result and status of the shared dot unit
  typedef struct packed {
    logic       valid;
    logic       busy;
    cvxq_dotv_t dot;
    cvxq_tag_t  tag;
  } cvxq_dot_t;

endpackage

// ----- src/cvxq_vstore.sv -----
// Vertex store: one write port, one registered read port, x and y side by side.
// Depends on cvxq_pkg for sizes and the coordinate type.
module cvxq_vstore
  import cvxq_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  cvxq_coord_t      wr_x,
  input  cvxq_coord_t      wr_y,
  input  logic [IDX_W-1:0] rd_addr,
  output cvxq_coord_t      rd_x,
  output cvxq_coord_t      rd_y
);

  cvxq_coord_t x_mem [MAX_VERTICES];
  cvxq_coord_t y_mem [MAX_VERTICES];
  cvxq_coord_t rd_x_r;
  cvxq_coord_t rd_y_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_mem[wr_addr] <= wr_x;
      y_mem[wr_addr] <= wr_y;
    end
  end

  always_ff @(posedge clk) begin
    rd_x_r <= x_mem[rd_addr];
    rd_y_r <= y_mem[rd_addr];
  end

  assign rd_x = rd_x_r;
  assign rd_y = rd_y_r;

endmodule

// ----- src/cvxq_dot_unit.sv -----
// Shared two-term dot product unit: operand register, two multipliers, add/sub.
// Three register stages, one request per cycle. Depends on cvxq_pkg.
module cvxq_dot_unit
  import cvxq_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cvxq_req_t req,
  output cvxq_dot_t rsp
);

  logic       s0_v_r;
  logic       s0_sub_r;
  cvxq_op_t   s0_a0_r, s0_b0_r, s0_a1_r, s0_b1_r;
  cvxq_tag_t  s0_tag_r;

  logic       s1_v_r;
  logic       s1_sub_r;
  cvxq_prod_t p0_r, p1_r;
  cvxq_tag_t  s1_tag_r;

  logic       s2_v_r;
  cvxq_dotv_t dot_r;
  cvxq_tag_t  s2_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s0_v_r <= req.valid;
      s1_v_r <= s0_v_r;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s0_sub_r <= req.sub;
    s0_a0_r  <= req.a0;
    s0_b0_r  <= req.b0;
    s0_a1_r  <= req.a1;
    s0_b1_r  <= req.b1;
    s0_tag_r <= req.tag;

    s1_sub_r <= s0_sub_r;
    p0_r     <= s0_a0_r * s0_b0_r;
    p1_r     <= s0_a1_r * s0_b1_r;
    s1_tag_r <= s0_tag_r;

    dot_r    <= s1_sub_r ? (DOT_W'(p0_r) - DOT_W'(p1_r))
                         : (DOT_W'(p0_r) + DOT_W'(p1_r));
    s2_tag_r <= s1_tag_r;
  end

  assign rsp.valid = s2_v_r;
  assign rsp.busy  = s0_v_r | s1_v_r | s2_v_r;
  assign rsp.dot   = dot_r;
  assign rsp.tag   = s2_tag_r;

endmodule

// ----- src/convex_polygon_query.sv -----
// Convex polygon query block. A load transaction writes one vertex and an unused code writes
// nothing; either gives an all-zero result through the finish step and the output register.
// A support or containment query walks the first vertex_count vertices (0 reads as 1, above
// 16 as 16) through one shared dot product unit, one vertex per cycle from the single read
// port of the vertex store, then drains the three-stage unit; a containment query makes
// one extra read that closes the last edge. Each result passes from the finish step into
// the output register, and the next transaction is accepted once the block is idle again.
// The block takes one transaction at a time; a finished result waits in the output register
// while the next transaction is accepted, and a result still waiting there holds back the
// finish of the following one.
// Depends on cvxq_pkg, cvxq_vstore and cvxq_dot_unit.
module convex_polygon_query
  import cvxq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [FUNC_W-1:0]      in_func,
  input  logic [SLOT_W-1:0]      in_vertex_slot,
  input  logic signed [COORD_WIDTH-1:0] in_vec_x,
  input  logic signed [COORD_WIDTH-1:0] in_vec_y,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [SLOT_W-1:0]      out_support_index,
  output logic signed [COORD_WIDTH-1:0] out_support_x,
  output logic signed [COORD_WIDTH-1:0] out_support_y,
  output logic                   out_inside_res,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CNT_W-1:0]       cfg_data
);

  cvxq_state_t       state_r, state_nxt;
  logic [CNT_W-1:0]  vcount_r;
  logic [FUNC_W-1:0] func_r;
  cvxq_coord_t       qx_r, qy_r;
  logic [NCNT_W-1:0] k_r, k_nxt;
  logic [NCNT_W-1:0] k_end_r;
  logic [NCNT_W-1:0] n_eff;

  logic              rd_v_r;
  logic              rd_first_r;
  logic [IDX_W-1:0]  rd_idx_r;
  cvxq_coord_t       prev_x_r, prev_y_r;

  logic [IDX_W-1:0]  best_idx_r;
  cvxq_coord_t       best_x_r, best_y_r;
  cvxq_dotv_t        best_dot_r;
  logic              inside_r;

  logic              out_valid_r;
  logic [SLOT_W-1:0] out_idx_r;
  cvxq_coord_t       out_x_r, out_y_r;
  logic              out_in_r;

  logic              accept;
  logic              start_query;
  logic              issue;
  logic              fire;
  logic              is_contain;
  logic              wr_en;
  logic [IDX_W-1:0]  rd_addr;
  cvxq_coord_t       rd_x, rd_y;
  cvxq_op_t          ex, ey, ax, ay;
  cvxq_req_t         req;
  cvxq_dot_t         rsp;
  cvxq_dotv_t        dot_val;

  assign cfg_ready  = 1'b1;
  assign in_stall   = (state_r != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign is_contain = (func_r == FUNC_CONTAIN);
  assign start_query = accept && (in_func == FUNC_SUPPORT || in_func == FUNC_CONTAIN);
  assign wr_en      = accept && (in_func == FUNC_LOAD) && (int'(in_vertex_slot) < MAX_VERTICES);

  // clamp the register to the range of vertices in use
  always_comb begin
    if (vcount_r == '0) begin
      n_eff = NCNT_W'(1);
    end else if (int'(vcount_r) > MAX_VERTICES) begin
      n_eff = NCNT_W'(MAX_VERTICES);
    end else begin
      n_eff = NCNT_W'(vcount_r);
    end
  end

  // the closing read of a containment walk wraps to vertex 0
  assign rd_addr = (is_contain && k_r == k_end_r) ? '0 : k_r[IDX_W-1:0];

  cvxq_vstore u_vstore (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_vertex_slot[IDX_W-1:0]),
    .wr_x    (in_vec_x),
    .wr_y    (in_vec_y),
    .rd_addr (rd_addr),
    .rd_x    (rd_x),
    .rd_y    (rd_y)
  );

  // operands: direction and vertex for support, edge terms for containment
  always_comb begin
    ex = OPW'(rd_x) - OPW'(prev_x_r);
    ey = OPW'(rd_y) - OPW'(prev_y_r);
    ax = (OPW'(qx_r) <<< 1) - (OPW'(prev_x_r) <<< 1) - ex;
    ay = (OPW'(qy_r) <<< 1) - (OPW'(prev_y_r) <<< 1) - ey;
    req.tag.idx = rd_idx_r;
    req.tag.x   = rd_x;
    req.tag.y   = rd_y;
    if (is_contain) begin
      req.valid = rd_v_r && !rd_first_r;
      req.sub   = 1'b1;
      req.a0    = ey;
      req.b0    = ax;
      req.a1    = ex;
      req.b1    = ay;
    end else begin
      req.valid = rd_v_r;
      req.sub   = 1'b0;
      req.a0    = OPW'(qx_r);
      req.b0    = OPW'(rd_x);
      req.a1    = OPW'(qy_r);
      req.b1    = OPW'(rd_y);
    end
  end

  cvxq_dot_unit u_dot (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
  );

  assign dot_val = rsp.dot;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    issue     = 1'b0;
    fire      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          k_nxt     = '0;
          state_nxt = start_query ? ST_RUN : ST_FINISH;
        end
      end
      ST_RUN: begin
        issue = 1'b1;
        k_nxt = k_r + NCNT_W'(1);
        if (k_r == k_end_r) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_r && !rsp.busy) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          fire      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      vcount_r    <= CNT_W'(1);
      k_r         <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      rd_v_r  <= issue;
      if (cfg_valid && cfg_ready) begin
        vcount_r <= cfg_data;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      func_r     <= in_func;
      qx_r       <= in_vec_x;
      qy_r       <= in_vec_y;
      k_end_r    <= (in_func == FUNC_CONTAIN) ? n_eff : n_eff - NCNT_W'(1);
      best_idx_r <= '0;
      best_x_r   <= '0;
      best_y_r   <= '0;
      inside_r   <= 1'b1;
    end else if (rsp.valid) begin
      if (is_contain) begin
        if (dot_val < 0) begin
          inside_r <= 1'b0;
        end
      end else if (rsp.tag.idx == '0 || dot_val > best_dot_r) begin
        // first vertex seeds the running maximum; ties keep the earlier vertex
        best_dot_r <= dot_val;
        best_idx_r <= rsp.tag.idx;
        best_x_r   <= rsp.tag.x;
        best_y_r   <= rsp.tag.y;
      end
    end
    if (issue) begin
      rd_first_r <= (k_r == '0);
      rd_idx_r   <= rd_addr;
    end
    if (rd_v_r) begin
      prev_x_r <= rd_x;
      prev_y_r <= rd_y;
    end
    if (fire) begin
      out_idx_r <= (func_r == FUNC_SUPPORT) ? SLOT_W'(best_idx_r) : '0;
      out_x_r   <= (func_r == FUNC_SUPPORT) ? best_x_r : '0;
      out_y_r   <= (func_r == FUNC_SUPPORT) ? best_y_r : '0;
      out_in_r  <= (func_r == FUNC_CONTAIN) ? inside_r : 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_support_index = out_idx_r;
  assign out_support_x     = out_x_r;
  assign out_support_y     = out_y_r;
  assign out_inside_res    = out_in_r;

  a_stall_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("input not held off after an accepted transaction");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_FINISH))
    else $error("result presented outside the finish step");

  a_unit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (!rsp.busy && !rd_v_r))
    else $error("dot unit still working while idle");

  a_one_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_inside_res && out_support_index != '0))
    else $error("result mixes support and containment fields");

endmodule

// ----- verif/convex_polygon_query_test.sv -----
// Self-checking testbench for convex_polygon_query: loads convex polygons, runs support and
// containment queries under random sender gaps and receiver stalls, checks every result.
// Depends on cvxq_pkg and the convex_polygon_query RTL.
module convex_polygon_query_test;
  import cvxq_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_SPARE = 2'd3;
  localparam int IDLE_LIMIT = 4000;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int PHASE_ITEMS = 125;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SLOT_W-1:0] slot;
    cvxq_coord_t       x;
    cvxq_coord_t       y;
  } poly_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0] idx;
    cvxq_coord_t       sx;
    cvxq_coord_t       sy;
    logic              in_res;
  } poly_answer_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FUNC_W-1:0] in_func = '0;
  logic [SLOT_W-1:0] in_vertex_slot = '0;
  logic signed [COORD_WIDTH-1:0] in_vec_x = '0;
  logic signed [COORD_WIDTH-1:0] in_vec_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [SLOT_W-1:0] out_support_index;
  logic signed [COORD_WIDTH-1:0] out_support_x;
  logic signed [COORD_WIDTH-1:0] out_support_y;
  logic out_inside_res;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;

  convex_polygon_query u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_vertex_slot    (in_vertex_slot),
    .in_vec_x          (in_vec_x),
    .in_vec_y          (in_vec_y),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_support_index (out_support_index),
    .out_support_x     (out_support_x),
    .out_support_y     (out_support_y),
    .out_inside_res    (out_inside_res),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_data          (cfg_data)
  );

  always #1 clk = ~clk;

  poly_item_t   pending[$];
  poly_answer_t answer_q[$];

  // predictor state
  cvxq_coord_t      vx_mem [MAX_VERTICES];
  cvxq_coord_t      vy_mem [MAX_VERTICES];
  logic [CNT_W-1:0] poly_count = 5'd1;

  // stimulus-side copy of the current polygon
  cvxq_coord_t gen_x [MAX_VERTICES];
  cvxq_coord_t gen_y [MAX_VERTICES];
  int poly_cx, poly_cy, poly_rad;

  int err_count = 0;
  int items_taken = 0;
  int results_checked = 0;
  int settings_written = 0;
  int idle_cycles = 0;
  logic in_fire = 1'b0;

  task automatic report_mismatch(input string field, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch in %s: got %h expected %h (result %0d)", field, got, want,
             results_checked);
    err_count++;
  endtask

  function automatic poly_answer_t query_polygon(input poly_item_t it);
    poly_answer_t ans;
    int n, best, j;
    longint qx, qy, d, best_dot, vx, vy, ex, ey, ax, ay, t;
    logic in_poly;
    ans = '0;
    qx = $signed(it.x);
    qy = $signed(it.y);
    n = (poly_count == 0) ? 1 : (poly_count > MAX_VERTICES) ? MAX_VERTICES : int'(poly_count);
    case (it.func)
      FUNC_LOAD: begin
        if (it.slot < MAX_VERTICES) begin
          vx_mem[it.slot] = it.x;
          vy_mem[it.slot] = it.y;
        end
      end
      FUNC_SUPPORT: begin
        best = 0;
        best_dot = qx * longint'(vx_mem[0]) + qy * longint'(vy_mem[0]);
        for (int i = 1; i < n; i++) begin
          d = qx * longint'(vx_mem[i]) + qy * longint'(vy_mem[i]);
          // strict compare: ties keep the lowest index
          if (d > best_dot) begin
            best_dot = d;
            best = i;
          end
        end
        ans.idx = best[SLOT_W-1:0];
        ans.sx = vx_mem[best];
        ans.sy = vy_mem[best];
      end
      FUNC_CONTAIN: begin
        in_poly = 1'b1;
        for (int i = 0; i < n; i++) begin
          j = (i + 1 == n) ? 0 : i + 1;
          vx = longint'(vx_mem[i]);
          vy = longint'(vy_mem[i]);
          ex = longint'(vx_mem[j]) - vx;
          ey = longint'(vy_mem[j]) - vy;
          ax = 2 * qx - 2 * vx - ex;
          ay = 2 * qy - 2 * vy - ey;
          t = ey * ax - ex * ay;
          if (t < 0) in_poly = 1'b0;
        end
        ans.in_res = in_poly;
      end
      default: begin
      end
    endcase
    return ans;
  endfunction

  function automatic int clamp_coord(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic int rand_span(input int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  task automatic push_item(input logic [FUNC_W-1:0] func, input int slot, input int x,
                           input int y);
    poly_item_t it;
    it.func = func;
    it.slot = SLOT_W'(slot);
    it.x = COORD_WIDTH'(x);
    it.y = COORD_WIDTH'(y);
    if (func == FUNC_LOAD) begin
      gen_x[it.slot] = it.x;
      gen_y[it.slot] = it.y;
    end
    pending.insert(pending.size(), it);
  endtask

  // Load a convex polygon of n vertices in clockwise order into slots 0..n-1.
  task automatic queue_polygon(input int n);
    real ang, step, rad;
    if ($urandom_range(0, 3) == 0) begin
      poly_cx = 0;
      poly_cy = 0;
      rad = 32000.0;
    end else begin
      poly_cx = rand_span(8000);
      poly_cy = rand_span(8000);
      rad = $urandom_range(16, 20000);
    end
    poly_rad = $rtoi(rad);
    step = 6.283185307 / n;
    ang = $urandom_range(0, 6283) / 1000.0;
    for (int k = 0; k < n; k++) begin
      push_item(FUNC_LOAD, k,
                clamp_coord(poly_cx + $rtoi(rad * $cos(ang))),
                clamp_coord(poly_cy + $rtoi(rad * $sin(ang))));
      ang = ang - step * (0.6 + $urandom_range(0, 40) / 100.0);
    end
  endtask

  task automatic queue_random(input int n, input int count);
    int r, k, m, span;
    int px, py;
    for (int c = 0; c < count; c++) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        m = $urandom_range(0, 9);
        if (m == 0) push_item(FUNC_SUPPORT, $urandom, 0, 0);
        else if (m < 3) push_item(FUNC_SUPPORT, $urandom, rand_span(16), rand_span(16));
        else push_item(FUNC_SUPPORT, $urandom, $urandom, $urandom);
      end else if (r < 85) begin
        m = $urandom_range(0, 9);
        span = poly_rad + poly_rad / 3 + 4;
        k = $urandom_range(0, n - 1);
        if (m < 5) begin
          px = clamp_coord(poly_cx + rand_span(span));
          py = clamp_coord(poly_cy + rand_span(span));
        end else if (m < 7) begin
          px = $urandom;
          py = $urandom;
        end else if (m < 8) begin
          // exactly on a vertex
          px = int'(gen_x[k]);
          py = int'(gen_y[k]);
        end else begin
          // midpoint of an edge, nudged a little either way
          m = (k + 1 == n) ? 0 : k + 1;
          px = clamp_coord((longint'(gen_x[k]) + longint'(gen_x[m])) / 2 + rand_span(1));
          py = clamp_coord((longint'(gen_y[k]) + longint'(gen_y[m])) / 2 + rand_span(1));
        end
        push_item(FUNC_CONTAIN, $urandom, px, py);
      end else if (r < 95) begin
        // stray load that may bend the polygon out of shape
        if ($urandom_range(0, 1) == 0)
          push_item(FUNC_LOAD, $urandom, $urandom, $urandom);
        else
          push_item(FUNC_LOAD, $urandom, clamp_coord(poly_cx + rand_span(poly_rad + 4)),
                    clamp_coord(poly_cy + rand_span(poly_rad + 4)));
      end else begin
        push_item(FUNC_SPARE, $urandom, $urandom, $urandom);
      end
    end
  endtask

  task automatic drain_all();
    while (pending.size() != 0 || answer_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [CNT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    poly_count = value;
    settings_written++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // input driver: bursts of random length separated by random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && !in_fire) begin
      // hold the stalled transaction
    end else if (gap_left != 0) begin
      gap_left--;
      in_valid <= 1'b0;
    end else if (pending.size() == 0) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= 1'b1;
      in_func <= pending[0].func;
      in_vertex_slot <= pending[0].slot;
      in_vec_x <= pending[0].x;
      in_vec_y <= pending[0].y;
      if (burst_left <= 1) begin
        burst_left = $urandom_range(1, 30);
        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 26);
      end else begin
        burst_left--;
      end
    end
  end

  // result stall pattern, with one long hold-off while the sender keeps offering
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && items_taken > 200 && pending.size() > 40) begin
      hold_done = 1'b1;
      hold_left = HOLD_OFF_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(5, 60);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 1) == 1);
        default: out_stall <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  // sample both channels, predict on input, check on output
  always @(posedge clk) begin : monitor
    poly_item_t   taken;
    poly_answer_t got, want;
    in_fire <= in_valid && !in_stall;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_support_index, out_support_x, out_support_y, out_inside_res};
        if (answer_q.size() == 0) begin
          report_mismatch("result with nothing pending", 16'(got.idx), 16'd0);
        end else begin
          want = answer_q.pop_front();
          if (got.idx !== want.idx)
            report_mismatch("support_index", 16'(got.idx), 16'(want.idx));
          if (got.sx !== want.sx) report_mismatch("support_x", got.sx, want.sx);
          if (got.sy !== want.sy) report_mismatch("support_y", got.sy, want.sy);
          if (got.in_res !== want.in_res)
            report_mismatch("inside_res", 16'(got.in_res), 16'(want.in_res));
        end
        results_checked++;
      end
      if (in_valid && !in_stall) begin
        taken = '{in_func, in_vertex_slot, in_vec_x, in_vec_y};
        answer_q.insert(answer_q.size(), query_polygon(taken));
        if (pending.size() != 0) void'(pending.pop_front());
        items_taken++;
      end
    end
  end

  // watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CNT_W-1:0] counts [8];
    int n;
    counts = '{5'd31, 5'd0, 5'd1, 5'd2, 5'd3, 5'd16, 5'd9, 5'd0};
    counts[6] = CNT_W'($urandom_range(4, 15));
    counts[7] = CNT_W'($urandom_range(0, 31));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    write_vertex_count(5'd4);
    // square at the corners of the coordinate range, clockwise
    push_item(FUNC_LOAD, 0, -32768, -32768);
    push_item(FUNC_LOAD, 1, -32768, 32767);
    push_item(FUNC_LOAD, 2, 32767, 32767);
    push_item(FUNC_LOAD, 3, 32767, -32768);
    push_item(FUNC_SUPPORT, 0, 0, 0);
    push_item(FUNC_SUPPORT, 15, 32767, 32767);
    push_item(FUNC_SUPPORT, 0, -32768, -32768);
    push_item(FUNC_SUPPORT, 5, 32767, -32768);
    push_item(FUNC_SUPPORT, 10, -32768, 32767);
    push_item(FUNC_CONTAIN, 0, 0, 0);
    push_item(FUNC_CONTAIN, 15, 32767, 32767);
    push_item(FUNC_CONTAIN, 0, -32768, 0);
    push_item(FUNC_CONTAIN, 0, -32768, -32768);
    push_item(FUNC_SPARE, 15, -1, -1);
    push_item(FUNC_LOAD, 15, 0, 0);
    // shrink to a small square so points can fall outside
    push_item(FUNC_LOAD, 0, -16, -16);
    push_item(FUNC_LOAD, 1, -16, 16);
    push_item(FUNC_LOAD, 2, 16, 16);
    push_item(FUNC_LOAD, 3, 16, -16);
    push_item(FUNC_CONTAIN, 0, 17, 0);
    push_item(FUNC_CONTAIN, 0, -32768, 32767);
    // duplicate vertex: zero-length edge and a tie in the support search
    push_item(FUNC_LOAD, 1, -16, -16);
    push_item(FUNC_SUPPORT, 0, -32768, 0);
    push_item(FUNC_CONTAIN, 0, 0, 0);
    push_item(FUNC_CONTAIN, 0, -16, 0);
    drain_all();

    for (int p = 0; p < 8; p++) begin
      write_vertex_count(counts[p]);
      n = (counts[p] == 0) ? 1 : (counts[p] > MAX_VERTICES) ? MAX_VERTICES : int'(counts[p]);
      queue_polygon(n);
      queue_random(n, PHASE_ITEMS);
      drain_all();
    end

    repeat (40) @(posedge clk);
    $display("covered %0d input transactions and %0d checked results over %0d vertex counts",
             items_taken, results_checked, settings_written);
    $display("support, containment, stray loads and unused codes under random gaps and stalls");
    if (err_count == 0 && answer_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results never arrived", err_count, answer_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
src/cvxq_pkg.sv
src/cvxq_vstore.sv
src/cvxq_dot_unit.sv
src/convex_polygon_query.sv
verif/convex_polygon_query_test.sv
